[rtl/core/cgos_pkg.sv]
`timescale 1ns / 1ps
package cgos_pkg;

  localparam int POS_W    = 16;
  localparam int RADIUS_W = 16;
  localparam int MASS_W   = 32;
  localparam int ID_W     = 24;
  localparam int DIST_W   = 16;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [APB_AW-1:0] REG_FALLBACK_ADDR = 3'd0;
  localparam logic [DIST_W-1:0] FALLBACK_RESET    = 16'hFFFF;

  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [RADIUS_W-1:0] radius_t;
  typedef logic [MASS_W-1:0]   mass_t;
  typedef logic [ID_W-1:0]     ident_t;
  typedef logic [DIST_W-1:0]   dist_t;
  typedef logic [APB_AW-1:0]   apb_addr_t;
  typedef logic [APB_DW-1:0]   apb_data_t;

endpackage

[rtl/core/cell_grid_owner_search_unit.sv]
`timescale 1ns / 1ps
// Halo store with a cell-grid owner search. After reset the unit clears its cell head
// memory, one cell a cycle, with busy high until all 2**(3*GRID_SIDE_BITS) cells are
// clear. An insert (cmd 0) returns nothing; an insert into a full store is dropped at
// once. A query (cmd 1) walks the up to 27 cells around the particle, newest halo
// first: each cell in the grid takes a head read, and each halo visited takes a
// memory read, three squared distances and the squared radius on one shared
// multiplier, then the compare. The result comes on owner_id, found and
// within_radius with done high for exactly one cycle as busy falls; the receiver
// cannot stall it. Write fallback_max_distance only while idle.
module cell_grid_owner_search_unit #(
  parameter int GRID_SIDE_BITS = 5,
  parameter int MAX_HALOS      = 4096,
  parameter int COORD_BITS     = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     cmd,
  input  cgos_pkg::pos_t           pos_x,
  input  cgos_pkg::pos_t           pos_y,
  input  cgos_pkg::pos_t           pos_z,
  input  cgos_pkg::radius_t        halo_radius,
  input  cgos_pkg::mass_t          halo_mass,
  input  cgos_pkg::ident_t         halo_id,
  output logic                     done,
  output cgos_pkg::ident_t         owner_id,
  output logic                     found,
  output logic                     within_radius,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  cgos_pkg::apb_addr_t      paddr,
  input  cgos_pkg::apb_data_t      pwdata,
  output cgos_pkg::apb_data_t      prdata,
  output logic                     pready
);

  import cgos_pkg::*;

  localparam int G     = GRID_SIDE_BITS;
  localparam int CW    = COORD_BITS;
  localparam int HW    = $clog2(MAX_HALOS);
  localparam int CELLS = 1 << (3 * G);
  localparam int CAW   = 3 * G;
  localparam int LW    = HW + 1;
  localparam int MW    = (CW > RADIUS_W) ? CW : RADIUS_W;
  localparam int SUMW  = 2 * CW + 2;
  localparam int CMPW  = (SUMW > 2 * DIST_W) ? SUMW : 2 * DIST_W;
  localparam int HRW   = LW + 3 * CW + RADIUS_W + MASS_W + ID_W;
  localparam logic [G-1:0]  SIDE_MAX = {G{1'b1}};
  localparam logic [HW:0]   COUNT_MAX = (HW + 1)'(MAX_HALOS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_INS   = 3'd2;
  localparam logic [2:0] ST_CELL  = 3'd3;
  localparam logic [2:0] ST_HEAD  = 3'd4;
  localparam logic [2:0] ST_HALO  = 3'd5;
  localparam logic [2:0] ST_MUL   = 3'd6;
  localparam logic [2:0] ST_CMP   = 3'd7;

  logic [2:0]     state;
  logic [CAW-1:0] clr;
  logic [HW:0]    count;
  dist_t          fallback_max_distance;

  logic [CW-1:0]  qx, qy, qz;
  radius_t        in_radius;
  mass_t          in_mass;
  ident_t         in_ident;
  logic [1:0]     dx, dy, dz;

  logic [LW-1:0]  cur_link;
  logic [CW-1:0]  hx, hy, hz;
  radius_t        cur_radius;
  mass_t          cur_mass;
  ident_t         cur_ident;
  logic [1:0]     mcnt;
  logic [SUMW-1:0] acc;
  logic [2*RADIUS_W-1:0] r2;

  logic [2*DIST_W-1:0] best_d2;
  mass_t          best_mass;
  ident_t         owner;
  logic           b_found, b_cont;

  logic           head_we;
  logic [CAW-1:0] head_waddr, head_raddr;
  logic [LW-1:0]  head_wdata, head_rdata;
  logic           halo_we;
  logic [HW-1:0]  halo_raddr;
  logic [HRW-1:0] halo_wdata, halo_rdata;

  logic [CW-1:0]  in_x, in_y, in_z;
  logic [G-1:0]   ix, iy, iz;
  logic           in_grid, last_cell;
  logic [CW-1:0]  da, db, dsel;
  logic [MW-1:0]  mop;
  logic [2*MW-1:0] prod;
  logic [CMPW-1:0] d2_ext;
  logic           accept;

  assign in_x   = CW'(pos_x);
  assign in_y   = CW'(pos_y);
  assign in_z   = CW'(pos_z);
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign prdata = (paddr[APB_AW-1] == 1'b0) ? APB_DW'(fallback_max_distance) : '0;

  assign ix = qx[CW-1 -: G] + G'(dx) - G'(1);
  assign iy = qy[CW-1 -: G] + G'(dy) - G'(1);
  assign iz = qz[CW-1 -: G] + G'(dz) - G'(1);
  assign in_grid = (dx != 2'd0 || qx[CW-1 -: G] != '0) && (dx != 2'd2 || qx[CW-1 -: G] != SIDE_MAX)
                && (dy != 2'd0 || qy[CW-1 -: G] != '0) && (dy != 2'd2 || qy[CW-1 -: G] != SIDE_MAX)
                && (dz != 2'd0 || qz[CW-1 -: G] != '0) && (dz != 2'd2 || qz[CW-1 -: G] != SIDE_MAX);
  assign last_cell = (dx == 2'd2) && (dy == 2'd2) && (dz == 2'd2);

  always_comb begin
    case (mcnt)
      2'd0:    begin da = qx; db = hx; end
      2'd1:    begin da = qy; db = hy; end
      default: begin da = qz; db = hz; end
    endcase
    dsel = (da > db) ? da - db : db - da;
    mop  = (mcnt == 2'd3) ? MW'(cur_radius) : MW'(dsel);
    prod = (2*MW)'(mop) * (2*MW)'(mop);
  end

  assign d2_ext = CMPW'(acc);

  always_comb begin
    head_we    = 1'b0;
    head_waddr = clr;
    head_wdata = '0;
    if (state == ST_CLEAR) begin
      head_we = 1'b1;
    end else if (state == ST_INS) begin
      head_we    = 1'b1;
      head_waddr = {qz[CW-1 -: G], qy[CW-1 -: G], qx[CW-1 -: G]};
      head_wdata = {1'b1, count[HW-1:0]};
    end
    head_raddr = (state == ST_IDLE) ? {in_z[CW-1 -: G], in_y[CW-1 -: G], in_x[CW-1 -: G]}
                                    : {iz, iy, ix};
    halo_we    = (state == ST_INS);
    halo_wdata = {head_rdata, qx, qy, qz, in_radius, in_mass, in_ident};
    halo_raddr = (state == ST_HEAD) ? head_rdata[HW-1:0] : cur_link[HW-1:0];
  end

  cgos_ram #(.WIDTH(LW), .DEPTH(CELLS)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (head_raddr),
    .rdata (head_rdata)
  );

  cgos_ram #(.WIDTH(HRW), .DEPTH(1 << HW)) u_halo_ram (
    .clk   (clk),
    .we    (halo_we),
    .waddr (count[HW-1:0]),
    .wdata (halo_wdata),
    .raddr (halo_raddr),
    .rdata (halo_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fallback_max_distance <= FALLBACK_RESET;
    end else if (psel && penable && pwrite && paddr[APB_AW-1] == REG_FALLBACK_ADDR[APB_AW-1]) begin
      fallback_max_distance <= pwdata[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr   <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == {CAW{1'b1}}) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            qx        <= in_x;
            qy        <= in_y;
            qz        <= in_z;
            in_radius <= halo_radius;
            in_mass   <= halo_mass;
            in_ident  <= halo_id;
            dx        <= 2'd0;
            dy        <= 2'd0;
            dz        <= 2'd0;
            best_d2   <= (2*DIST_W)'(fallback_max_distance) * (2*DIST_W)'(fallback_max_distance);
            best_mass <= '0;
            owner     <= '0;
            b_found   <= 1'b0;
            b_cont    <= 1'b0;
            if (cmd == CMD_QUERY) begin
              state <= ST_CELL;
            end else if (count != COUNT_MAX) begin
              state <= ST_INS;
            end
          end
        end
        ST_INS: begin
          count <= count + 1'b1;
          state <= ST_IDLE;
        end
        ST_CELL: begin
          if (in_grid) begin
            state <= ST_HEAD;
          end else if (last_cell) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end else begin
            dz <= (dz == 2'd2) ? 2'd0 : dz + 2'd1;
            if (dz == 2'd2) begin
              dy <= (dy == 2'd2) ? 2'd0 : dy + 2'd1;
              if (dy == 2'd2) begin
                dx <= dx + 2'd1;
              end
            end
          end
        end
        ST_HEAD: begin
          if (head_rdata[LW-1]) begin
            state <= ST_HALO;
          end else if (last_cell) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end else begin
            state <= ST_CELL;
            dz <= (dz == 2'd2) ? 2'd0 : dz + 2'd1;
            if (dz == 2'd2) begin
              dy <= (dy == 2'd2) ? 2'd0 : dy + 2'd1;
              if (dy == 2'd2) begin
                dx <= dx + 2'd1;
              end
            end
          end
        end
        ST_HALO: begin
          {cur_link, hx, hy, hz, cur_radius, cur_mass, cur_ident} <= halo_rdata;
          mcnt  <= 2'd0;
          acc   <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          mcnt <= mcnt + 2'd1;
          if (mcnt == 2'd3) begin
            r2    <= prod[2*RADIUS_W-1:0];
            state <= ST_CMP;
          end else begin
            acc <= acc + SUMW'(prod);
          end
        end
        ST_CMP: begin
          if (d2_ext < CMPW'(r2)) begin
            if (cur_mass > best_mass) begin
              best_mass <= cur_mass;
              owner     <= cur_ident;
              b_found   <= 1'b1;
              b_cont    <= 1'b1;
            end
          end else if (!b_cont && d2_ext < CMPW'(best_d2)) begin
            best_d2 <= acc[2*DIST_W-1:0];
            owner   <= cur_ident;
            b_found <= 1'b1;
          end
          if (cur_link[LW-1]) begin
            state <= ST_HALO;
          end else if (last_cell) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end else begin
            state <= ST_CELL;
            dz <= (dz == 2'd2) ? 2'd0 : dz + 2'd1;
            if (dz == 2'd2) begin
              dy <= (dy == 2'd2) ? 2'd0 : dy + 2'd1;
              if (dy == 2'd2) begin
                dx <= dx + 2'd1;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign owner_id      = b_found ? owner : '0;
  assign found         = b_found;
  assign within_radius = b_cont;

  assert property (@(posedge clk) disable iff (rst) count <= COUNT_MAX)
    else $error("halo count beyond capacity");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result transfer while busy");
  assert property (@(posedge clk) disable iff (rst) (done && within_radius) |-> found)
    else $error("containment without owner");
  assert property (@(posedge clk) disable iff (rst) (done && !found) |-> (owner_id == '0))
    else $error("owner id set with no owner");
  assert property (@(posedge clk) disable iff (rst) (accept && cmd == CMD_QUERY) |=> busy)
    else $error("query not started");

endmodule

[rtl/core/cgos_ram.sv]
`timescale 1ns / 1ps
module cgos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
